### rtl/core/rmbcm_pkg.sv
// ---------------------------------------------------------------------------
// rmbcm_pkg
// Shared types and constants for the RGB matrix BCM scan driver core.
// ---------------------------------------------------------------------------
package rmbcm_pkg;

  // Frame store geometry: 512 pixels of 24-bit colour.
  localparam int unsigned STORE_DEPTH = 512;
  localparam int unsigned STORE_AW    = 9;
  localparam int unsigned COLOR_W     = 24;
  localparam int unsigned ROW_W       = 4;
  localparam int unsigned PLANE_W     = 3;
  localparam int unsigned LIT_W       = 23;
  localparam int unsigned BASE_W      = 16;

  // Configuration register indexes.
  localparam logic CFG_RUN_ENABLE   = 1'b0;
  localparam logic CFG_ON_TIME_BASE = 1'b1;

  // Scan phase, one-hot.
  typedef enum logic [2:0] {
    PH_SHIFT = 3'b001,
    PH_LATCH = 3'b010,
    PH_LIT   = 3'b100
  } phase_t;

  // Sequencer position that travels alongside the frame store read.
  typedef struct packed {
    logic               run;
    phase_t             phase;
    logic               half;
    logic [PLANE_W-1:0] plane;
    logic               clk_phase;
    logic [ROW_W-1:0]   row;
    logic               frame_start;
  } scan_meta_t;

endpackage

### rtl/core/rmbcm_ram.sv
// ---------------------------------------------------------------------------
// rmbcm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module rmbcm_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // A read and a write to the same entry in one cycle return the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/rgb_matrix_bcm_scan_driver_core.sv
// ---------------------------------------------------------------------------
// rgb_matrix_bcm_scan_driver_core
// Frame store and binary code modulation scan sequencer for a HUB75 panel.
// ---------------------------------------------------------------------------
// Each input request is one panel tick and may also write one pixel of the
// 512 x 24-bit frame store; each tick produces exactly one output request
// carrying the panel pin state. The block takes one request per clock cycle,
// so the sustained rate is one tick per cycle while the receiver keeps up. The
// tick is captured by the registered read of the frame store and stage one,
// and its pin state is then loaded into the output register. The scan
// position for a tick is known before the tick arrives, so the store is read
// in the accepting cycle and the pins are formed from the registered read
// data. While the receiver holds off, up to two ticks wait inside the block
// and the input stalls. A pixel write lands in the same cycle as that tick's
// read, and the read returns the old contents, so the pins always show the
// store as it was before the tick's own write. After reset the block sweeps
// the whole store to black, one entry a cycle, during which no tick is
// accepted; configuration writes are taken throughout. Configuration must
// only be changed while no tick is in flight.
// ---------------------------------------------------------------------------
module rgb_matrix_bcm_scan_driver_core
  import rmbcm_pkg::*;
#(
  parameter int unsigned POSITIONS  = 16,
  parameter int unsigned SEGMENTS   = 4,
  parameter int unsigned SCAN_LINES = 4,
  parameter int unsigned PLANES     = 8
) (
  input  logic        clk,
  input  logic        rst_n,

  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata,

  // Tick requests in.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // [8:0] pixel_addr, [32:9] pixel_color, rest zero
  input  logic [0:0]  in_tuser,    // [0] cmd

  // Panel pin state out.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [3:0] row_addr, [4] red_top, [5] green_top,
                                   // [6] blue_top, [7] red_bottom, [8] green_bottom,
                                   // [9] blue_bottom, [10] shift_clock, [11] latch,
                                   // [12] output_enable, rest zero
  output logic [0:0]  out_tuser    // [0] frame_start
);

  localparam int unsigned ROW_PIXELS = POSITIONS * SEGMENTS;
  localparam int unsigned PIX_W      = (ROW_PIXELS > 1) ? $clog2(ROW_PIXELS) : 1;

  // Configuration registers.
  logic              run_en_r;
  logic [BASE_W-1:0] base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_en_r <= 1'b0;
      base_r   <= BASE_W'(5);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_RUN_ENABLE:   run_en_r <= cfg_wdata[0];
        CFG_ON_TIME_BASE: base_r   <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  // Clearing sweep after reset.
  logic                clr_busy_r;
  logic [STORE_AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + STORE_AW'(1);
      if (clr_addr_r == STORE_AW'(STORE_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Handshake and pipeline control.
  logic       s1_valid_r;
  scan_meta_t s1_meta_r;
  logic       out_valid_r;
  logic       out_free;
  logic       in_accept;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !clr_busy_r && (!s1_valid_r || out_free);
  assign in_accept = in_tvalid && in_tready;

  // Input fields.
  logic                cmd;
  logic [STORE_AW-1:0] pixel_addr;
  logic [COLOR_W-1:0]  pixel_color;

  assign cmd         = in_tuser[0];
  assign pixel_addr  = in_tdata[8:0];
  assign pixel_color = in_tdata[32:9];

  // Scan position registers.
  phase_t             phase_r, phase_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic               half_r, half_nxt;
  logic [PLANE_W-1:0] plane_r, plane_nxt;
  logic [PIX_W-1:0]   pix_r, pix_nxt;
  logic               cp_r, cp_nxt;
  logic [LIT_W-1:0]   lit_r, lit_nxt;

  logic [BASE_W-1:0] base_eff;
  logic [LIT_W-1:0]  lit_target;
  logic [LIT_W-1:0]  lit_inc;

  // A base of zero behaves as one; the target doubles with each plane.
  assign base_eff   = (base_r == '0) ? BASE_W'(1) : base_r;
  assign lit_target = LIT_W'(base_eff) << plane_r;
  assign lit_inc    = lit_r + LIT_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    row_nxt   = row_r;
    half_nxt  = half_r;
    plane_nxt = plane_r;
    pix_nxt   = pix_r;
    cp_nxt    = cp_r;
    lit_nxt   = lit_r;
    if (in_accept && run_en_r) begin
      case (phase_r)
        PH_SHIFT: begin
          // Data tick with the clock low, then the clock-high tick.
          if (!cp_r) begin
            cp_nxt = 1'b1;
          end else begin
            cp_nxt = 1'b0;
            if (pix_r == PIX_W'(ROW_PIXELS - 1)) begin
              pix_nxt   = '0;
              phase_nxt = PH_LATCH;
            end else begin
              pix_nxt = pix_r + PIX_W'(1);
            end
          end
        end
        PH_LATCH: begin
          phase_nxt = PH_LIT;
          lit_nxt   = '0;
        end
        PH_LIT: begin
          // The lit phase ends once the count reaches or passes the target,
          // then the scan moves to the next plane, half and row.
          if (lit_inc >= lit_target) begin
            phase_nxt = PH_SHIFT;
            lit_nxt   = '0;
            if (plane_r == PLANE_W'(PLANES - 1)) begin
              plane_nxt = '0;
              half_nxt  = !half_r;
              if (half_r) begin
                row_nxt = (row_r == ROW_W'(SCAN_LINES - 1)) ? '0 : row_r + ROW_W'(1);
              end
            end else begin
              plane_nxt = plane_r + PLANE_W'(1);
            end
          end else begin
            lit_nxt = lit_inc;
          end
        end
        default: begin
          phase_nxt = PH_SHIFT;
          pix_nxt   = '0;
          cp_nxt    = 1'b0;
          lit_nxt   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SHIFT;
      row_r   <= '0;
      half_r  <= 1'b0;
      plane_r <= '0;
      pix_r   <= '0;
      cp_r    <= 1'b0;
      lit_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      row_r   <= row_nxt;
      half_r  <= half_nxt;
      plane_r <= plane_nxt;
      pix_r   <= pix_nxt;
      cp_r    <= cp_nxt;
      lit_r   <= lit_nxt;
    end
  end

  // Frame store read address for the current scan position, wrapped to the
  // store depth.
  logic [31:0]         scan_idx;
  logic [STORE_AW-1:0] rd_addr;

  assign scan_idx = 32'(pix_r) + 32'(ROW_PIXELS) *
                    (32'(row_r) + 32'(SCAN_LINES) * 32'(half_r));
  assign rd_addr  = scan_idx[STORE_AW-1:0];

  // Frame store: the clearing sweep owns the write port until it finishes.
  logic                ram_we;
  logic [STORE_AW-1:0] ram_waddr;
  logic [COLOR_W-1:0]  ram_wdata;
  logic [COLOR_W-1:0]  ram_rdata;

  assign ram_we    = clr_busy_r || (in_accept && cmd);
  assign ram_waddr = clr_busy_r ? clr_addr_r : pixel_addr;
  assign ram_wdata = clr_busy_r ? '0 : pixel_color;

  rmbcm_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Stage one: the scan position that matches the read now in the RAM.
  scan_meta_t meta_cur;

  always_comb begin
    meta_cur.run         = run_en_r;
    meta_cur.phase       = phase_r;
    meta_cur.half        = half_r;
    meta_cur.plane       = plane_r;
    meta_cur.clk_phase   = cp_r;
    meta_cur.row         = row_r;
    meta_cur.frame_start = (phase_r == PH_SHIFT) && (row_r == '0) && !half_r &&
                           (plane_r == '0) && (pix_r == '0) && !cp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (out_free) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_meta_r <= meta_cur;
    end
  end

  // Pin state from the stored pixel and the scan position.
  logic [7:0]  red_bits, green_bits, blue_bits;
  logic        r_bit, g_bit, b_bit;
  logic [15:0] pins;
  logic        fs_pin;

  assign red_bits   = ram_rdata[7:0];
  assign green_bits = ram_rdata[15:8];
  assign blue_bits  = ram_rdata[23:16];
  assign r_bit      = red_bits[s1_meta_r.plane];
  assign g_bit      = green_bits[s1_meta_r.plane];
  assign b_bit      = blue_bits[s1_meta_r.plane];

  always_comb begin
    pins   = '0;
    fs_pin = 1'b0;
    if (s1_meta_r.run) begin
      pins[3:0] = s1_meta_r.row;
      case (s1_meta_r.phase)
        PH_SHIFT: begin
          // Only the half being scanned carries data; the other is dark.
          if (!s1_meta_r.half) begin
            pins[6:4] = {b_bit, g_bit, r_bit};
          end else begin
            pins[9:7] = {b_bit, g_bit, r_bit};
          end
          pins[10] = s1_meta_r.clk_phase;
          fs_pin   = s1_meta_r.frame_start;
        end
        PH_LATCH: pins[11] = 1'b1;
        PH_LIT:   pins[12] = 1'b1;
        default:  pins[3:0] = '0;
      endcase
    end
  end

  // Output register.
  logic [15:0] out_data_r;
  logic        out_fs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_data_r <= pins;
      out_fs_r   <= fs_pin;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_fs_r;

`ifndef NO_ASSERTIONS
  // No tick may be taken while the store is still being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_tready)
    else $error("tick accepted during the clearing sweep");

  // A running latch tick is always followed by the lit phase.
  a_latch_then_lit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && run_en_r && phase_r == PH_LATCH) |=> (phase_r == PH_LIT))
    else $error("latch tick not followed by the lit phase");

  // A stalled stage-one entry keeps its scan position.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_free) |=> (s1_valid_r && $stable(s1_meta_r)))
    else $error("stage one changed while stalled");

  // Latch and output enable never coincide, and data lines are dark then.
  a_latch_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r[11] || out_data_r[12])) |->
      (out_data_r[9:4] == '0 && !(out_data_r[11] && out_data_r[12])))
    else $error("data lines active outside the shift phase");
`endif

endmodule

### tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the RGB matrix BCM scan driver core.
// ---------------------------------------------------------------------------
// Tick requests go into the block and pin-state requests come out. For every
// tick that is accepted, a tick-by-tick model of the frame store and the scan
// sequencer works out the expected panel pins. These are queued and compared,
// field by field, with each pin-state request as it leaves the block. A short
// directed part comes first. Runs of random ticks follow, under several
// on-time settings and with the sequencer stopped and restarted, and take the
// scan from the upper half into the lower half. Both sides idle at
// random, and once the receiver holds off for a long stretch.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rmbcm_pkg::*;

  // Geometry of the block under test, which is also what the model assumes.
  localparam int POSITIONS    = 16;
  localparam int SEGMENTS     = 4;
  localparam int SCAN_LINES   = 4;
  localparam int PLANES       = 8;
  localparam int ROW_PIXELS   = POSITIONS * SEGMENTS;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 6;
  // The receiver's long hold-off, in cycles.
  localparam int LONG_HOLD    = 400;
  // The run is abandoned after this many cycles in which no request moves on
  // either side. The clearing pass after reset and the long hold-off are both
  // far below it.
  localparam int QUIET_LIMIT  = 4000;

  // One set of panel pins, as carried by a pin-state request.
  typedef struct packed {
    logic [ROW_W-1:0] row_addr;
    logic             red_top;
    logic             green_top;
    logic             blue_top;
    logic             red_bottom;
    logic             green_bottom;
    logic             blue_bottom;
    logic             shift_clock;
    logic             latch;
    logic             output_enable;
    logic             frame_start;
  } pin_state_t;

  // Every input of the block has a known value from time zero.
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_addr   = CFG_RUN_ENABLE;
  logic [15:0] cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [0:0]  out_tuser;

  rgb_matrix_bcm_scan_driver_core #(
    .POSITIONS  (POSITIONS),
    .SEGMENTS   (SEGMENTS),
    .SCAN_LINES (SCAN_LINES),
    .PLANES     (PLANES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // -------------------------------------------------------------------------
  // Scan model state. It is written only by the checking process below.
  // -------------------------------------------------------------------------
  logic             scan_run;
  logic [15:0]      on_base;
  logic [23:0]      pixel_store [STORE_DEPTH];
  logic [ROW_W-1:0] scan_row;
  logic             scan_half;
  logic [2:0]       scan_plane;
  logic [5:0]       scan_pixel;
  logic             scan_clk_phase;
  phase_t           scan_phase;
  logic [22:0]      lit_ticks;

  pin_state_t  pin_states_due [$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  // Controls for the idling of both sides, set by the test sequence.
  logic        tx_idle_on    = 1'b1;
  logic        rx_idle_on    = 1'b1;
  int unsigned hold_requests = 0;

  // Advances the scan model by one tick and returns the pins for that tick.
  // The pins are formed from the store as it was before this tick's write.
  function automatic pin_state_t scan_tick(input logic        write_pixel,
                                           input logic [8:0]  waddr,
                                           input logic [23:0] wcolor);
    pin_state_t  pins;
    logic [8:0]  idx;
    logic [23:0] px;
    logic [15:0] base_eff;
    logic [22:0] target;
    pins = '0;
    if (scan_run) begin
      pins.row_addr = scan_row;
      case (scan_phase)
        PH_SHIFT: begin
          idx = 9'(int'(scan_pixel) +
                   ROW_PIXELS * (int'(scan_row) + SCAN_LINES * int'(scan_half)));
          px  = pixel_store[idx];
          // Only the half being scanned gets colour; the other half sees zero.
          if (!scan_half) begin
            pins.red_top      = px[scan_plane];
            pins.green_top    = px[scan_plane + 8];
            pins.blue_top     = px[scan_plane + 16];
          end else begin
            pins.red_bottom   = px[scan_plane];
            pins.green_bottom = px[scan_plane + 8];
            pins.blue_bottom  = px[scan_plane + 16];
          end
          pins.shift_clock = scan_clk_phase;
          pins.frame_start = (scan_row == 0) && !scan_half && (scan_plane == 0) &&
                             (scan_pixel == 0) && !scan_clk_phase;
          // Each pixel takes a data tick and then a clock-high tick.
          if (!scan_clk_phase) begin
            scan_clk_phase = 1'b1;
          end else begin
            scan_clk_phase = 1'b0;
            if (scan_pixel == 6'(ROW_PIXELS - 1)) begin
              scan_pixel = '0;
              scan_phase = PH_LATCH;
            end else begin
              scan_pixel = scan_pixel + 6'd1;
            end
          end
        end
        PH_LATCH: begin
          pins.latch = 1'b1;
          scan_phase = PH_LIT;
          lit_ticks  = '0;
        end
        PH_LIT: begin
          // A base of zero behaves as one. The comparison is against the
          // current target, so a base lowered while lit ends the phase at once.
          base_eff = (on_base == 16'd0) ? 16'd1 : on_base;
          target   = {7'd0, base_eff} << scan_plane;
          pins.output_enable = 1'b1;
          lit_ticks = lit_ticks + 23'd1;
          if (lit_ticks >= target) begin
            scan_phase = PH_SHIFT;
            lit_ticks  = '0;
            if (scan_plane == 3'(PLANES - 1)) begin
              scan_plane = '0;
              if (scan_half) begin
                scan_half = 1'b0;
                scan_row  = (scan_row == ROW_W'(SCAN_LINES - 1)) ? '0 : scan_row + 1'b1;
              end else begin
                scan_half = 1'b1;
              end
            end else begin
              scan_plane = scan_plane + 3'd1;
            end
          end
        end
        default: begin
          // An unused phase code gives idle pins and falls back to shifting.
          pins.row_addr  = '0;
          scan_phase     = PH_SHIFT;
          scan_pixel     = '0;
          scan_clk_phase = 1'b0;
          lit_ticks      = '0;
        end
      endcase
    end
    if (write_pixel)
      pixel_store[waddr] = wcolor;
    return pins;
  endfunction

  task automatic check_pin(input string name, input int unsigned want,
                           input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // -------------------------------------------------------------------------
  // Checking process. Everything is sampled at the rising edge, where the
  // testbench's own inputs have been stable since the falling edge.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    pin_state_t want;
    if (!rst_n) begin
      for (int i = 0; i < STORE_DEPTH; i++)
        pixel_store[i] = '0;
      scan_run       = 1'b0;
      on_base        = 16'd5;
      scan_row       = '0;
      scan_half      = 1'b0;
      scan_plane     = '0;
      scan_pixel     = '0;
      scan_clk_phase = 1'b0;
      scan_phase     = PH_SHIFT;
      lit_ticks      = '0;
      quiet_cycles   = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_RUN_ENABLE:   scan_run = cfg_wdata[0];
          CFG_ON_TIME_BASE: on_base  = cfg_wdata;
          default: ;
        endcase
      end
      // A result can never belong to the tick accepted at the same edge, so
      // the output side is checked before the new expectation is queued.
      if (out_tvalid && out_tready) begin
        if (pin_states_due.size() == 0) begin
          $display("%0t ns: pin-state request with none expected, actual %h/%h",
                   $time, out_tdata, out_tuser);
          mismatch_count++;
        end else begin
          want = pin_states_due.pop_front();
          check_pin("row_addr",      want.row_addr,      out_tdata[3:0]);
          check_pin("red_top",       want.red_top,       out_tdata[4]);
          check_pin("green_top",     want.green_top,     out_tdata[5]);
          check_pin("blue_top",      want.blue_top,      out_tdata[6]);
          check_pin("red_bottom",    want.red_bottom,    out_tdata[7]);
          check_pin("green_bottom",  want.green_bottom,  out_tdata[8]);
          check_pin("blue_bottom",   want.blue_bottom,   out_tdata[9]);
          check_pin("shift_clock",   want.shift_clock,   out_tdata[10]);
          check_pin("latch",         want.latch,         out_tdata[11]);
          check_pin("output_enable", want.output_enable, out_tdata[12]);
          check_pin("frame_start",   want.frame_start,   out_tuser[0]);
        end
      end
      if (in_tvalid && in_tready)
        pin_states_due.push_back(scan_tick(in_tuser[0], in_tdata[8:0], in_tdata[32:9]));
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  // Watchdog: gives up once nothing has moved for too long.
  initial begin
    while (quiet_cycles < QUIET_LIMIT)
      @(negedge clk);
    $display("FAILURE");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Receiver. With idling on, runs of ready alternate with shorter stalls, and
  // a long hold-off is served whenever the test sequence asks for one.
  // -------------------------------------------------------------------------
  initial begin
    int unsigned hold_served;
    logic        rx_ready;
    int unsigned rx_left;
    hold_served = 0;
    rx_ready    = 1'b0;
    rx_left     = 0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        out_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (!rx_idle_on) begin
        out_tready <= 1'b1;
      end else begin
        if (rx_left == 0) begin
          rx_ready = !rx_ready;
          rx_left  = rx_ready ? $urandom_range(1, 24) : $urandom_range(1, 6);
        end
        rx_left--;
        out_tready <= rx_ready;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Sender. All tasks below start and end on a falling edge.
  // -------------------------------------------------------------------------
  int unsigned tx_burst_left = 0;

  // Offers one tick request and returns once it has been accepted. With
  // idling on, ticks go out in bursts with random gaps between them.
  task automatic send_tick(input logic write_pixel, input logic [8:0] addr,
                           input logic [23:0] color);
    if (tx_idle_on && tx_burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      tx_burst_left = $urandom_range(1, 40);
    end
    if (tx_burst_left != 0)
      tx_burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= write_pixel;
    in_tdata  <= {7'd0, color, addr};
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_ticks(input int count, input int write_one_in);
    for (int n = 0; n < count; n++)
      send_tick($urandom_range(0, write_one_in - 1) == 0, 9'($urandom_range(0, 511)),
                24'($urandom));
  endtask

  // Registers may only change once every pin-state request is out and the
  // block has had a few cycles more to settle.
  task automatic drain_pins;
    in_tvalid <= 1'b0;
    while (pin_states_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_register(input logic index, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= index;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Tests.
  // -------------------------------------------------------------------------

  // Straight after reset the sequencer is stopped: pins stay idle while pixel
  // writes still land, including the last store entry.
  task automatic test_stopped_writes;
    send_tick(1'b1, 9'd511, 24'hFFFFFF);
    send_tick(1'b1, 9'd1,   24'hFFFFFF);
    send_tick(1'b0, 9'd0,   24'hFFFFFF);
    send_tick(1'b1, 9'd2,   24'h5AA55A);
    send_tick(1'b1, 9'd256, 24'h00FF00);
    send_tick(1'b1, 9'd3,   24'h800180);
  endtask

  // With the default on-time, the first tick reads pixel zero and writes it
  // too: the data tick must show the old black value and the clock-high tick
  // the new one. The first tick also carries the frame start.
  task automatic test_same_tick_write;
    drain_pins();
    set_register(CFG_RUN_ENABLE, 16'd1);
    send_tick(1'b1, 9'd0, 24'hFFFFFF);
    send_tick(1'b0, 9'd0, 24'h000000);
    send_tick(1'b1, 9'd1, 24'h000000);
    send_tick(1'b0, 9'd5, 24'h123456);
    send_tick(1'b1, 9'd4, 24'hFFFFFF);
    send_tick(1'b1, 9'd4, 24'h000000);
  endtask

  // Random ticks with the on-time left at its reset value, through the first
  // latch and lit phases and into the shifting of the next plane.
  task automatic test_default_on_time;
    send_random_ticks(140, 2);
  endtask

  // The largest base keeps plane one lit for a long time; dropping the base to
  // zero (acting as one) while lit must end the lit phase on the next tick.
  task automatic test_on_time_extremes;
    drain_pins();
    set_register(CFG_ON_TIME_BASE, 16'hFFFF);
    send_random_ticks(150, 3);
    drain_pins();
    set_register(CFG_ON_TIME_BASE, 16'd0);
    send_random_ticks(60, 3);
  endtask

  // Stopping mid-scan holds the position with idle pins; writes go on.
  task automatic test_stop_and_resume;
    drain_pins();
    set_register(CFG_RUN_ENABLE, 16'd0);
    send_random_ticks(20, 2);
    drain_pins();
    set_register(CFG_RUN_ENABLE, 16'd1);
    send_random_ticks(60, 4);
  endtask

  // With a base of one a half takes a little under 1300 ticks, so this run
  // carries the scan through the remaining planes of the upper half and well
  // into the lower half. The first part has no idling on either side.
  task automatic test_long_scan;
    drain_pins();
    set_register(CFG_ON_TIME_BASE, 16'd1);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_random_ticks(470, 8);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_random_ticks(470, 8);
  endtask

  // The receiver holds off while ticks are offered back to back, so the block
  // fills up and must stall its input without losing or repeating a tick.
  task automatic test_input_stall;
    hold_requests++;
    tx_idle_on = 1'b0;
    send_random_ticks(100, 2);
    tx_idle_on = 1'b1;
  endtask

  // Rounds under random settings: mostly short on-times, now and then any
  // 16-bit base, and the sequencer sometimes stopped.
  task automatic test_random_settings;
    logic [15:0] base;
    logic        run;
    for (int round = 0; round < 8; round++) begin
      base = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
      run  = ($urandom_range(0, 4) != 0);
      drain_pins();
      set_register(CFG_ON_TIME_BASE, base);
      set_register(CFG_RUN_ENABLE, {15'd0, run});
      send_random_ticks(15, 2);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_stopped_writes();
    test_same_tick_write();
    test_default_on_time();
    test_on_time_extremes();
    test_stop_and_resume();
    test_input_stall();
    test_long_scan();
    test_random_settings();

    // Let every expected request arrive, then watch a little longer for any
    // stray request that nothing accounts for.
    drain_pins();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### filelist.f
rtl/core/rmbcm_pkg.sv
rtl/core/rmbcm_ram.sv
rtl/core/rgb_matrix_bcm_scan_driver_core.sv
tb/tb_top.sv
